// ----- rtl/kdbt_pkg.sv -----
// Shared types and constants for the keypad debounce and backlight timer.
package kdbt_pkg;

  // Key count and field widths
  localparam int NUM_KEYS   = 5;
  localparam int TIMER_W    = 16;
  localparam int COUNT_W    = 8;
  localparam int WAKE_W     = 2;
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  // Saturation limits and wake length
  localparam logic [TIMER_W-1:0] TIMER_MAX  = '1;
  localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;
  localparam logic [WAKE_W-1:0]  WAKE_EVALS = 2'd2;

  // Register reset values
  localparam logic [TIMER_W-1:0] SCAN_PERIOD_RST   = 16'd10;
  localparam logic [TIMER_W-1:0] HANDLE_PERIOD_RST = 16'd100;
  localparam logic [TIMER_W-1:0] TIMEOUT_RST       = 16'd20000;
  localparam logic [COUNT_W-1:0] THRESHOLD_RST     = 8'd6;

  // Register index, taken from paddr[3:2]
  typedef enum logic [1:0] {
    REG_SCAN_PERIOD   = 2'd0,
    REG_HANDLE_PERIOD = 2'd1,
    REG_TIMEOUT       = 2'd2,
    REG_THRESHOLD     = 2'd3
  } reg_idx_t;

  // Configuration bundle from the register block to the datapath
  typedef struct packed {
    logic [TIMER_W-1:0] scan_period;
    logic [TIMER_W-1:0] handle_period;
    logic [TIMER_W-1:0] backlight_timeout;
    logic [COUNT_W-1:0] debounce_threshold;
  } cfg_t;

endpackage

// ----- rtl/kdbt_regs.sv -----
// APB configuration registers for the keypad debounce and backlight timer.
module kdbt_regs
  import kdbt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel & penable & pwrite & pready;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.scan_period        <= SCAN_PERIOD_RST;
      cfg.handle_period      <= HANDLE_PERIOD_RST;
      cfg.backlight_timeout  <= TIMEOUT_RST;
      cfg.debounce_threshold <= THRESHOLD_RST;
    end else if (wr_en) begin
      case (idx)
        REG_SCAN_PERIOD:   cfg.scan_period        <= pwdata[TIMER_W-1:0];
        REG_HANDLE_PERIOD: cfg.handle_period      <= pwdata[TIMER_W-1:0];
        REG_TIMEOUT:       cfg.backlight_timeout  <= pwdata[TIMER_W-1:0];
        REG_THRESHOLD:     cfg.debounce_threshold <= pwdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Read mux, zero extended
  always_comb begin
    case (idx)
      REG_SCAN_PERIOD:   prdata = {{(APB_DATA_W-TIMER_W){1'b0}}, cfg.scan_period};
      REG_HANDLE_PERIOD: prdata = {{(APB_DATA_W-TIMER_W){1'b0}}, cfg.handle_period};
      REG_TIMEOUT:       prdata = {{(APB_DATA_W-TIMER_W){1'b0}}, cfg.backlight_timeout};
      REG_THRESHOLD:     prdata = {{(APB_DATA_W-COUNT_W){1'b0}}, cfg.debounce_threshold};
      default:           prdata = '0;
    endcase
  end

endmodule

// ----- rtl/keypad_debounce_backlight_timer.sv -----
// Keypad debounce with backlight timer: tick datapath, state and result register.
// The result of each accepted tick item is registered in the output register.
// Throughput: one item per cycle while in_stall is low; the state update is single-pass
// logic ahead of the state and result registers, so a new item is taken while a result
// is still held. in_stall is high only while a result waits and out_stall holds it.
// Reset: synchronous; timers, counts and modes clear, backlight on, registers to defaults.
module keypad_debounce_backlight_timer
  import kdbt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // tick items
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [NUM_KEYS-1:0]   key_levels,
  // result items
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [NUM_KEYS-1:0]   key_events,
  output logic                  backlight,
  output logic                  evaluated,
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t cfg;

  kdbt_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // State
  logic [TIMER_W-1:0] scan_timer, scan_timer_next;
  logic [TIMER_W-1:0] handle_timer, handle_timer_next;
  logic [TIMER_W-1:0] idle_timer, idle_timer_next;
  logic [COUNT_W-1:0] low_cnt [NUM_KEYS];
  logic [COUNT_W-1:0] low_cnt_next [NUM_KEYS];
  logic               dark_mode, dark_mode_next;
  logic               wake_pending, wake_pending_next;
  logic [WAKE_W-1:0]  wake_count, wake_count_next;
  logic               light_state, light_state_next;
  logic [NUM_KEYS-1:0] events_next;
  logic               eval_next;

  logic in_accept;

  assign in_stall  = out_valid & out_stall;
  assign in_accept = in_valid & ~in_stall;

  // Per-tick update: timers, scan, evaluation, timeout
  always_comb begin
    logic [TIMER_W-1:0]  st, ht, it;
    logic [COUNT_W-1:0]  cnt [NUM_KEYS];
    logic [NUM_KEYS-1:0] hit;
    logic                any;
    logic                wp;
    logic [WAKE_W-1:0]   wc;
    logic                dm;
    logic                lt;

    st = (scan_timer   == TIMER_MAX) ? TIMER_MAX : scan_timer + 1'b1;
    ht = (handle_timer == TIMER_MAX) ? TIMER_MAX : handle_timer + 1'b1;
    it = (idle_timer   == TIMER_MAX) ? TIMER_MAX : idle_timer + 1'b1;
    wp = wake_pending;
    wc = wake_count;
    dm = dark_mode;
    lt = light_state;
    hit = '0;
    any = 1'b0;

    // sample keys
    for (int i = 0; i < NUM_KEYS; i++) begin
      cnt[i] = low_cnt[i];
    end
    if (st >= cfg.scan_period) begin
      st = '0;
      for (int i = 0; i < NUM_KEYS; i++) begin
        if (!key_levels[i] && low_cnt[i] != COUNT_MAX) begin
          cnt[i] = low_cnt[i] + 1'b1;
        end
      end
    end

    // evaluate presses
    eval_next = (ht >= cfg.handle_period);
    if (eval_next) begin
      ht = '0;
      for (int i = 0; i < NUM_KEYS; i++) begin
        hit[i] = (cnt[i] >= cfg.debounce_threshold);
      end
      any = |hit;
      if (!dm) begin
        if (any) begin
          it = '0;
        end
      end else begin
        if (any) begin
          wp = 1'b1;
          lt = 1'b1;
        end
        if (wp) begin
          wc = wc + 1'b1;
        end
        if (wc >= WAKE_EVALS) begin
          wc = '0;
          wp = 1'b0;
          dm = 1'b0;
        end
        if (dm) begin
          it = '0;
        end
      end
      for (int i = 0; i < NUM_KEYS; i++) begin
        cnt[i] = '0;
      end
      // backlight timeout, checked on evaluation ticks only
      if (!dm && it >= cfg.backlight_timeout) begin
        it = '0;
        lt = 1'b0;
        dm = 1'b1;
      end
    end

    events_next = dark_mode ? '0 : hit;
    scan_timer_next   = st;
    handle_timer_next = ht;
    idle_timer_next   = it;
    for (int i = 0; i < NUM_KEYS; i++) begin
      low_cnt_next[i] = cnt[i];
    end
    dark_mode_next    = dm;
    wake_pending_next = wp;
    wake_count_next   = wc;
    light_state_next  = lt;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_timer   <= '0;
      handle_timer <= '0;
      idle_timer   <= '0;
      for (int i = 0; i < NUM_KEYS; i++) begin
        low_cnt[i] <= '0;
      end
      dark_mode    <= 1'b0;
      wake_pending <= 1'b0;
      wake_count   <= '0;
      light_state  <= 1'b1;
    end else if (in_accept) begin
      scan_timer   <= scan_timer_next;
      handle_timer <= handle_timer_next;
      idle_timer   <= idle_timer_next;
      for (int i = 0; i < NUM_KEYS; i++) begin
        low_cnt[i] <= low_cnt_next[i];
      end
      dark_mode    <= dark_mode_next;
      wake_pending <= wake_pending_next;
      wake_count   <= wake_count_next;
      light_state  <= light_state_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_accept | (out_valid & out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      key_events <= events_next;
      backlight  <= light_state_next;
      evaluated  <= eval_next;
    end
  end

  // Checks
  a_normal_lit: assert property (@(posedge clk) disable iff (rst)
    !dark_mode |-> light_state)
    else $error("backlight off outside dark mode");

  a_wake_in_dark: assert property (@(posedge clk) disable iff (rst)
    wake_pending |-> dark_mode)
    else $error("wake pending outside dark mode");

  a_wake_count: assert property (@(posedge clk) disable iff (rst)
    wake_count < WAKE_EVALS)
    else $error("wake count past limit");

  a_events_on_eval: assert property (@(posedge clk) disable iff (rst)
    out_valid && key_events != '0 |-> evaluated)
    else $error("key event without evaluation");

  a_light_out: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> backlight == light_state)
    else $error("backlight output differs from state");

endmodule
